[design/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[design/hfp_pkg.sv]
// types, constants and helpers of the hex float text parser
// no dependencies; used by the interfaces and every module of the block
package hfp_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CHAR_W      = 8;
  localparam int DBL_W       = 64;
  localparam int USED_W      = 16;
  localparam int EXPV_W      = 30;
  localparam int BEXP_W      = 32;
  // working width of the biased exponent sum
  localparam int E_W         = ((COUNT_WIDTH > EXPV_W) ? COUNT_WIDTH : EXPV_W) + 4;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX     = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] KEEP_DIGITS = COUNT_WIDTH'(15);
  localparam logic [USED_W-1:0]      USED_MAX    = {USED_W{1'b1}};

  localparam logic [EXPV_W-1:0]        EXP_CAP   = EXPV_W'(100000000);
  localparam logic signed [BEXP_W-1:0] BEXP_MIN  = -(BEXP_W'(32'sd1073741824));
  localparam logic signed [BEXP_W-1:0] BEXP_STEP = BEXP_W'(4);

  localparam int EXP_BIAS_M1 = 1021;
  localparam int MANT_TOP    = 63;
  localparam int SUBN_MIN    = -53;
  localparam int EXP_MAX     = 2045;
  localparam int ROUND_SHIFT = 10;

  localparam logic [DBL_W-1:0] ROUND_HALF = 64'h0000_0000_0000_0200;
  localparam logic [DBL_W-1:0] INF_BITS   = 64'h7ff0_0000_0000_0000;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_UP    = 8'h50;
  localparam logic [CHAR_W-1:0] CH_LP    = 8'h70;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  typedef enum logic [3:0] {
    PH_MANT       = 4'b0001,
    PH_AFTER_P    = 4'b0010,
    PH_AFTER_SIGN = 4'b0100,
    PH_EXP_DIG    = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    END_PLAIN  = 2'd0,
    END_BAD    = 2'd1,
    END_BADEXP = 2'd2,
    END_EXP    = 2'd3
  } end_kind_e;

  // snapshot of the parse state when a number ends
  typedef struct packed {
    logic                     valid;
    end_kind_e                kind;
    logic                     sign;
    logic [DBL_W-1:0]         mant;
    logic [COUNT_WIDTH-1:0]   dig_cnt;
    logic                     pt_seen;
    logic [COUNT_WIDTH-1:0]   pt_pos;
    logic [COUNT_WIDTH-1:0]   zero_run;
    logic signed [BEXP_W-1:0] bexp;
    logic                     exp_neg;
    logic [EXPV_W-1:0]        exp_val;
    logic [COUNT_WIDTH-1:0]   used;
  } fin_req_t;

  typedef struct packed {
    logic [DBL_W-1:0]  double_bits;
    logic [DBL_W-1:0]  raw_mant;
    logic              raw_mant_ok;
    logic              digits_found;
    logic [USED_W-1:0] used_count;
  } res_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[design/hfp_in_if.sv]
// character channel into the parser: valid/ready plus one character item
// depends on hfp_pkg
interface hfp_in_if import hfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              start_req;
  logic              negative;

  modport source (output valid, output char_code, output start_req, output negative,
                  input ready);
  modport sink (input valid, input char_code, input start_req, input negative,
                output ready);
endinterface

[design/hfp_out_if.sv]
// result channel out of the parser: valid/ready plus one parsed number
// depends on hfp_pkg
interface hfp_out_if import hfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DBL_W-1:0]  double_bits;
  logic [DBL_W-1:0]  raw_mant;
  logic              raw_mant_ok;
  logic              digits_found;
  logic [USED_W-1:0] used_count;

  modport source (output valid, output double_bits, output raw_mant, output raw_mant_ok,
                  output digits_found, output used_count, input ready);
  modport sink (input valid, input double_bits, input raw_mant, input raw_mant_ok,
                input digits_found, input used_count, output ready);
endinterface

[design/hfp_scan.sv]
// per-character parse state: classifies a character, updates the state
// and flags the end of a number; depends on hfp_pkg and assert_macros.svh
`include "assert_macros.svh"

module hfp_scan import hfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              start_i,
  input  logic              negative_i,
  output fin_req_t          fin_o
);

  phase_e                   ph_q, ph_e, ph_d;
  logic [DBL_W-1:0]         mant_q, mant_e, mant_d;
  logic [COUNT_WIDTH-1:0]   dig_q, dig_e, dig_d;
  logic                     ptseen_q, ptseen_e, ptseen_d;
  logic [COUNT_WIDTH-1:0]   ptpos_q, ptpos_e, ptpos_d;
  logic [COUNT_WIDTH-1:0]   zrun_q, zrun_e, zrun_d;
  logic signed [BEXP_W-1:0] bexp_q, bexp_e, bexp_d;
  logic                     eneg_q, eneg_e, eneg_d;
  logic [EXPV_W-1:0]        eval_q, eval_e, eval_d;
  logic                     sign_q, sign_e, sign_d;
  logic [COUNT_WIDTH-1:0]   cc_q, cc_e, cc_d;
  logic [COUNT_WIDTH-1:0]   cbe_q, cbe_e, cbe_d;
  logic                     ended_q, ended_e, ended_d;

  logic              is_dec, is_hex, is_point, is_p, is_sign, is_term;
  logic [3:0]        hex_val;
  logic [EXPV_W+3:0] ev_ten;
  logic              fin_vld;
  end_kind_e         fin_kind;

  assign is_dec   = char_i inside {[CH_0:CH_9]};
  assign is_hex   = is_dec || (char_i inside {[CH_UA:CH_UF], [CH_LA:CH_LF]});
  assign is_point = (char_i == CH_POINT);
  assign is_p     = (char_i == CH_UP) || (char_i == CH_LP);
  assign is_sign  = (char_i == CH_PLUS) || (char_i == CH_MINUS);
  assign is_term  = (char_i < CH_POINT) || (char_i > CH_LP);
  // letters a..f and A..F share the low three bits
  assign hex_val  = is_dec ? char_i[3:0] : 4'(char_i[2:0]) + 4'd9;

  // state as seen by this character, after an optional restart
  always_comb begin
    if (start_i) begin
      ph_e     = PH_MANT;
      mant_e   = '0;
      dig_e    = '0;
      ptseen_e = 1'b0;
      ptpos_e  = '0;
      zrun_e   = '0;
      bexp_e   = '0;
      eneg_e   = 1'b0;
      eval_e   = '0;
      sign_e   = negative_i;
      cc_e     = '0;
      cbe_e    = '0;
      ended_e  = 1'b0;
    end else begin
      ph_e     = ph_q;
      mant_e   = mant_q;
      dig_e    = dig_q;
      ptseen_e = ptseen_q;
      ptpos_e  = ptpos_q;
      zrun_e   = zrun_q;
      bexp_e   = bexp_q;
      eneg_e   = eneg_q;
      eval_e   = eval_q;
      sign_e   = sign_q;
      cc_e     = cc_q;
      cbe_e    = cbe_q;
      ended_e  = ended_q;
    end
  end

  always_comb begin
    ph_d     = ph_e;
    mant_d   = mant_e;
    dig_d    = dig_e;
    ptseen_d = ptseen_e;
    ptpos_d  = ptpos_e;
    zrun_d   = zrun_e;
    bexp_d   = bexp_e;
    eneg_d   = eneg_e;
    eval_d   = eval_e;
    sign_d   = sign_e;
    cc_d     = cc_e;
    cbe_d    = cbe_e;
    fin_vld  = 1'b0;
    fin_kind = END_PLAIN;
    ev_ten   = {1'b0, eval_e, 3'b000} + {3'b000, eval_e, 1'b0};

    if (!ended_e) begin
      case (ph_e)
        PH_MANT: begin
          if (is_term) begin
            fin_vld  = 1'b1;
            fin_kind = END_PLAIN;
          end else if (is_point) begin
            if (ptseen_e) begin
              fin_vld  = 1'b1;
              fin_kind = END_BAD;
            end else begin
              ptseen_d = 1'b1;
              ptpos_d  = dig_e;
              cc_d     = sat_inc(cc_e);
            end
          end else if (is_p) begin
            cbe_d = cc_e;
            cc_d  = sat_inc(cc_e);
            ph_d  = PH_AFTER_P;
          end else if (is_hex) begin
            cc_d = sat_inc(cc_e);
            if (dig_e == '0 && hex_val == 4'd0) begin
              // leading zero: skipped, scales the value after the point
              zrun_d = sat_inc(zrun_e);
              if (ptseen_e && bexp_e > BEXP_MIN) begin
                bexp_d = bexp_e - BEXP_STEP;
              end
            end else begin
              if (dig_e < KEEP_DIGITS) begin
                mant_d = {mant_e[DBL_W-5:0], hex_val};
              end else if (hex_val != 4'd0) begin
                mant_d = mant_e | DBL_W'(1);
              end
              dig_d = sat_inc(dig_e);
            end
          end else begin
            fin_vld  = 1'b1;
            fin_kind = END_BAD;
          end
        end
        PH_AFTER_P, PH_AFTER_SIGN: begin
          if (ph_e == PH_AFTER_P && is_sign) begin
            eneg_d = (char_i == CH_MINUS);
            cc_d   = sat_inc(cc_e);
            ph_d   = PH_AFTER_SIGN;
          end else if (is_dec) begin
            eval_d = EXPV_W'(char_i[3:0]);
            cc_d   = sat_inc(cc_e);
            ph_d   = PH_EXP_DIG;
          end else begin
            fin_vld  = 1'b1;
            fin_kind = END_BADEXP;
          end
        end
        PH_EXP_DIG: begin
          if (is_dec) begin
            if (eval_e < EXP_CAP) begin
              eval_d = EXPV_W'(ev_ten + (EXPV_W+4)'(char_i[3:0]));
            end
            cc_d = sat_inc(cc_e);
          end else begin
            fin_vld  = 1'b1;
            fin_kind = END_EXP;
          end
        end
        default: begin
          fin_vld  = 1'b1;
          fin_kind = END_BAD;
        end
      endcase
    end
    ended_d = ended_e | fin_vld;
  end

  always_comb begin
    fin_o.valid    = fin_vld;
    fin_o.kind     = fin_kind;
    fin_o.sign     = sign_e;
    fin_o.mant     = mant_e;
    fin_o.dig_cnt  = dig_e;
    fin_o.pt_seen  = ptseen_e;
    fin_o.pt_pos   = ptpos_e;
    fin_o.zero_run = zrun_e;
    fin_o.bexp     = bexp_e;
    fin_o.exp_neg  = eneg_e;
    fin_o.exp_val  = eval_e;
    fin_o.used     = (fin_kind == END_BADEXP) ? cbe_e : cc_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_MANT;
      mant_q   <= '0;
      dig_q    <= '0;
      ptseen_q <= 1'b0;
      ptpos_q  <= '0;
      zrun_q   <= '0;
      bexp_q   <= '0;
      eneg_q   <= 1'b0;
      eval_q   <= '0;
      sign_q   <= 1'b0;
      cc_q     <= '0;
      cbe_q    <= '0;
      ended_q  <= 1'b0;
    end else if (fire_i) begin
      ph_q     <= ph_d;
      mant_q   <= mant_d;
      dig_q    <= dig_d;
      ptseen_q <= ptseen_d;
      ptpos_q  <= ptpos_d;
      zrun_q   <= zrun_d;
      bexp_q   <= bexp_d;
      eneg_q   <= eneg_d;
      eval_q   <= eval_d;
      sign_q   <= sign_d;
      cc_q     <= cc_d;
      cbe_q    <= cbe_d;
      ended_q  <= ended_d;
    end
  end

  // the first counted digit is nonzero, so the mantissa cannot be empty
  `ASSERT_PROP(a_dig_mant, clk_i, rst_ni, (dig_q != '0) |-> (mant_q != '0), "digits counted with zero mantissa")
  `ASSERT_NEVER(a_pt_pos, clk_i, rst_ni, ptpos_q > dig_q, "point position beyond digit count")
  // once ended, characters without a restart leave the state alone
  `ASSERT_PROP(a_ended_hold, clk_i, rst_ni, (fire_i && ended_q && !start_i) |=> (ended_q && $stable(mant_q) && $stable(cc_q)), "state changed after end of number")

endmodule

[design/hfp_pack.sv]
// turns the parse state at the end of a number into binary64 bits,
// the raw mantissa and the used count; depends on hfp_pkg
module hfp_pack import hfp_pkg::*; (
  input  fin_req_t fin_i,
  output res_t     res_o
);

  logic [DBL_W-1:0]       sgn;
  logic                   found;
  logic                   plain;
  logic [COUNT_WIDTH-1:0] pt;
  logic [COUNT_WIDTH-1:0] ic;
  logic [5:0]             msb;
  logic [5:0]             lz;
  logic signed [E_W-1:0]  bexp_x;
  logic signed [E_W-1:0]  diff;
  logic signed [E_W-1:0]  e_s;
  logic                   out_range;
  logic [5:0]             d;
  logic [10:0]            e_fld;
  logic [6:0]             sh;
  logic [DBL_W-1:0]       m_n;
  logic [DBL_W-1:0]       half;
  logic [DBL_W-1:0]       m_r;

  always_comb begin
    sgn   = {fin_i.sign, {(DBL_W-1){1'b0}}};
    found = (fin_i.dig_cnt != '0) || (fin_i.zero_run != '0);
    plain = (fin_i.kind == END_PLAIN);

    // position of the top set bit of the mantissa
    msb = '0;
    for (int i = 0; i < DBL_W; i++) begin
      if (fin_i.mant[i]) msb = 6'(i);
    end
    lz = 6'(MANT_TOP - 1) - msb;

    bexp_x = E_W'(fin_i.bexp);
    if (fin_i.kind == END_EXP) begin
      if (fin_i.exp_neg) bexp_x = bexp_x - $signed(E_W'(fin_i.exp_val));
      else               bexp_x = bexp_x + $signed(E_W'(fin_i.exp_val));
    end

    pt   = fin_i.pt_seen ? fin_i.pt_pos : fin_i.dig_cnt;
    ic   = (fin_i.dig_cnt > KEEP_DIGITS) ? KEEP_DIGITS : fin_i.dig_cnt;
    diff = $signed(E_W'(pt)) - $signed(E_W'(ic));
    e_s  = bexp_x + (diff <<< 2) + $signed(E_W'(EXP_BIAS_M1 + MANT_TOP))
           - $signed(E_W'(lz));

    out_range = (e_s < $signed(E_W'(SUBN_MIN))) || (e_s > $signed(E_W'(EXP_MAX)));

    // subnormal: shift the mantissa further right by the deficit
    if (e_s < 0) begin
      d     = 6'(-e_s);
      e_fld = '0;
    end else begin
      d     = '0;
      e_fld = e_s[10:0];
    end
    sh   = 7'(ROUND_SHIFT) + {1'b0, d};
    m_n  = fin_i.mant << lz;
    half = ROUND_HALF << d;
    // round half to even: guard bit plus sticky bits plus result lsb
    if (({1'b0, lz} < sh) && ((m_n & ((half << 1) + half - DBL_W'(1))) != '0)) begin
      m_r = m_n + half;
    end else begin
      m_r = m_n;
    end

    res_o.digits_found = found;
    res_o.used_count   = !found ? '0 :
                         (32'(fin_i.used) > 32'(USED_MAX)) ? USED_MAX
                                                           : USED_W'(fin_i.used);
    if (fin_i.dig_cnt == '0) begin
      res_o.double_bits = sgn;
      res_o.raw_mant    = '0;
      res_o.raw_mant_ok = plain;
    end else if (out_range) begin
      res_o.double_bits = (e_s > 0) ? (sgn | INF_BITS) : sgn;
      res_o.raw_mant    = '0;
      res_o.raw_mant_ok = 1'b0;
    end else begin
      // hidden bit carries into the exponent field
      res_o.double_bits = sgn + {1'b0, e_fld, 52'b0} + (m_r >> sh[5:0]);
      res_o.raw_mant    = plain ? fin_i.mant : '0;
      res_o.raw_mant_ok = plain;
    end
  end

endmodule

[design/hex_float_text_parser_unit.sv]
// Hex float text parser. Takes one character per transfer (hex digits, one
// point, optional p/P exponent with sign and decimal digits); the character
// after the number ends it and yields one result: binary64 bits rounded to
// nearest even, the raw mantissa and the character count. A character with
// start_req set opens a new number; after a result, characters without
// start_req are dropped. One character is taken every clock cycle, except
// while a terminating character waits for a stalled result to leave the
// output register. Each character passes an input register, then the parse
// state update and the normalize/round logic, and its result lands in the
// output register.
// depends on hfp_pkg, hfp_in_if, hfp_out_if, hfp_scan, hfp_pack
`include "assert_macros.svh"

module hex_float_text_parser_unit import hfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hfp_in_if.sink    in_i,
  hfp_out_if.source out_o
);

  logic              in_vld_q;
  logic [CHAR_W-1:0] char_q;
  logic              start_q;
  logic              neg_q;
  logic              in_rdy;
  logic              out_free;
  logic              fire;
  logic              out_vld_q;
  res_t              res_q;
  fin_req_t          fin;
  res_t              res;

  hfp_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .char_i     (char_q),
    .start_i    (start_q),
    .negative_i (neg_q),
    .fin_o      (fin)
  );

  hfp_pack u_pack (
    .fin_i (fin),
    .res_o (res)
  );

  // a character that ends a number needs room in the output register
  assign out_free = !out_vld_q || out_o.ready;
  assign fire     = in_vld_q && (!fin.valid || out_free);
  assign in_rdy   = !in_vld_q || fire;

  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      char_q  <= in_i.char_code;
      start_q <= in_i.start_req;
      neg_q   <= in_i.negative;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && fin.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && fin.valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.double_bits  = res_q.double_bits;
  assign out_o.raw_mant     = res_q.raw_mant;
  assign out_o.raw_mant_ok  = res_q.raw_mant_ok;
  assign out_o.digits_found = res_q.digits_found;
  assign out_o.used_count   = res_q.used_count;

  // a terminator waits while the previous result is stalled
  `ASSERT_PROP(a_term_wait, clk_i, rst_ni, (in_vld_q && fin.valid && out_vld_q && !out_o.ready) |=> (in_vld_q && $stable(char_q)), "terminator dropped under stall")
  // a character that ends nothing leaves a stalled result alone
  `ASSERT_PROP(a_res_hold, clk_i, rst_ni, (fire && !fin.valid && out_vld_q && !out_o.ready) |=> (out_vld_q && $stable(res_q)), "stalled result disturbed")
  `ASSERT_PROP(a_raw_zero, clk_i, rst_ni, (out_vld_q && !res_q.raw_mant_ok) |-> (res_q.raw_mant == '0), "raw mantissa set without its flag")
  `ASSERT_PROP(a_no_digits, clk_i, rst_ni, (out_vld_q && !res_q.digits_found) |-> (res_q.used_count == '0 && res_q.double_bits[DBL_W-2:0] == '0), "nonzero result without digits")

endmodule

[dv/tb_top.sv]
// testbench for the hex float text parser: character stream in, one result per number out
// depends on hfp_pkg, hfp_in_if, hfp_out_if and hex_float_text_parser_unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hfp_pkg::*;

  typedef logic [7:0] char_q_t[$];

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  hfp_in_if  in_if ();
  hfp_out_if out_if ();

  hex_float_text_parser_unit uut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parse state of the predictor, starting as after reset
  phase_e      ph = PH_MANT;
  logic [63:0] acc = '0;
  logic [15:0] ndig = '0;
  logic        has_point = 1'b0;
  logic [15:0] point_at = '0;
  logic [15:0] zrun = '0;
  longint      bin_exp = 0;
  logic        exp_neg = 1'b0;
  longint      exp_mag = 0;
  logic        neg_sign = 1'b0;
  logic [15:0] used_chars = '0;
  logic [15:0] used_before_p = '0;
  logic        number_closed = 1'b0;

  res_t        parsed_q[$];
  int          fail_cnt = 0;
  int          chars_taken = 0;
  int          cycles = 0;
  int          rx_hold_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  // normalize and round the collected digits into the result of one number
  function automatic res_t close_number(end_kind_e kind);
    res_t        r;
    logic [63:0] sgn, m, half, ebits;
    logic [15:0] used;
    longint      bexp, pt, ic, e;
    int          lz, d;
    bit          found;
    sgn = neg_sign ? 64'h8000_0000_0000_0000 : 64'd0;
    used = (kind == END_BADEXP) ? used_before_p : used_chars;
    found = (ndig != 0) || (zrun != 0);
    bexp = bin_exp;
    number_closed = 1'b1;
    if (kind == END_EXP) bexp += exp_neg ? -exp_mag : exp_mag;
    r = '0;
    r.digits_found = found;
    r.used_count = found ? used : 16'd0;
    r.double_bits = sgn;
    if (ndig == 0) begin
      r.raw_mant_ok = (kind == END_PLAIN);
      return r;
    end
    m = acc;
    lz = 0;
    while (!m[63]) begin
      m = m << 1;
      lz++;
    end
    lz = lz - 1;
    pt = has_point ? point_at : ndig;
    ic = (ndig > 15) ? 15 : ndig;
    e = bexp + (pt - ic) * 4 + 1084 - lz;
    d = 0;
    if (e < -53 || e > 2045) begin
      if (e > 2045) r.double_bits = sgn | 64'h7ff0_0000_0000_0000;
      return r;
    end
    if (e < 0) begin
      d = int'(-e);
      e = 0;
    end
    m = acc << lz;
    if (lz < 10 + d) begin
      half = 64'h200 << d;
      if ((m & (half * 3 - 64'd1)) != 0) m = m + half;
    end
    ebits = e;
    r.double_bits = sgn + (ebits << 52) + (m >> (10 + d));
    if (kind == END_PLAIN) begin
      r.raw_mant = acc;
      r.raw_mant_ok = 1'b1;
    end
    return r;
  endfunction

  // advance the parse by one character; returns 1 when the number ends here
  function automatic bit parse_char(input logic [7:0] c, input bit start, input bit neg,
                                    output res_t r);
    int k;
    bit is_dec;
    bit ends;
    r = '0;
    ends = 1'b0;
    if (start) begin
      ph = PH_MANT;
      acc = '0;
      ndig = '0;
      has_point = 1'b0;
      point_at = '0;
      zrun = '0;
      bin_exp = 0;
      exp_neg = 1'b0;
      exp_mag = 0;
      neg_sign = neg;
      used_chars = '0;
      used_before_p = '0;
      number_closed = 1'b0;
    end else if (number_closed) begin
      return 1'b0;
    end
    is_dec = (c >= "0" && c <= "9");
    if (is_dec) k = c - "0";
    else if (c >= "A" && c <= "F") k = c - "A" + 10;
    else if (c >= "a" && c <= "f") k = c - "a" + 10;
    else if (c == ".") k = 16;
    else if (c == "p" || c == "P") k = 17;
    else k = 18;
    case (ph)
      PH_MANT: begin
        if (c < "." || c > "p") begin
          r = close_number(END_PLAIN);
          ends = 1'b1;
        end else if (k == 16) begin
          if (has_point) begin
            r = close_number(END_BAD);
            ends = 1'b1;
          end else begin
            has_point = 1'b1;
            point_at = ndig;
            used_chars = bump(used_chars);
          end
        end else if (k == 17) begin
          used_before_p = used_chars;
          used_chars = bump(used_chars);
          ph = PH_AFTER_P;
        end else if (k < 16) begin
          used_chars = bump(used_chars);
          if (ndig == 0 && k == 0) begin
            // leading zero: only shifts the exponent once past the point
            zrun = bump(zrun);
            if (has_point && bin_exp > -1073741824) bin_exp -= 4;
          end else begin
            if (ndig < 15) acc = (acc << 4) | 64'(k);
            else if (k != 0) acc[0] = 1'b1;
            ndig = bump(ndig);
          end
        end else begin
          r = close_number(END_BAD);
          ends = 1'b1;
        end
      end
      PH_AFTER_P, PH_AFTER_SIGN: begin
        if (ph == PH_AFTER_P && (c == "-" || c == "+")) begin
          exp_neg = (c == "-");
          used_chars = bump(used_chars);
          ph = PH_AFTER_SIGN;
        end else if (is_dec) begin
          exp_mag = k;
          used_chars = bump(used_chars);
          ph = PH_EXP_DIG;
        end else begin
          r = close_number(END_BADEXP);
          ends = 1'b1;
        end
      end
      default: begin
        if (is_dec) begin
          if (exp_mag < 100000000) exp_mag = exp_mag * 10 + k;
          used_chars = bump(used_chars);
        end else begin
          r = close_number(END_EXP);
          ends = 1'b1;
        end
      end
    endcase
    return ends;
  endfunction

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  // mostly no idling, some short gaps, a few long ones
  function automatic int idle_len(bit on);
    int pick;
    pick = $urandom_range(99);
    if (!on || pick < 60) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
  endfunction

  // a code that ends the mantissa and is never a decimal digit
  function automatic logic [7:0] end_char();
    if ($urandom_range(1)) return 8'($urandom_range(8'h2d));
    return 8'($urandom_range(255, 8'h71));
  endfunction

  // inside the mantissa range but neither hex digit, point nor p
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h6f, 8'h2f));
    while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f")
           || c == "P");
    return c;
  endfunction

  function automatic char_q_t text_of(string s, logic [7:0] term);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    q.push_back(term);
    return q;
  endfunction

  function automatic char_q_t make_well_formed();
    char_q_t q;
    string   s;
    int      nz, nd, pt, v;
    bit      edgy;
    nz = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(2);
    nd = ($urandom_range(6) == 0) ? $urandom_range(24, 14) : $urandom_range(8);
    pt = ($urandom_range(2) == 0) ? -1 : $urandom_range(nz + nd);
    edgy = 1'($urandom_range(1));
    for (int i = 0; i <= nz + nd; i++) begin
      if (i == pt) q.push_back(".");
      if (i == nz + nd) break;
      if (i < nz) begin
        q.push_back("0");
      end else begin
        // digits near rounding ties and sticky bits
        if (edgy) begin
          case ($urandom_range(4))
            0: v = 0;
            1: v = 8;
            2: v = 15;
            3: v = 1;
            default: v = 7;
          endcase
        end else begin
          v = $urandom_range(15);
        end
        if (i == nz && v == 0) v = 8;
        q.push_back(hex_char(v));
      end
    end
    if ($urandom_range(9) < 7) begin
      q.push_back($urandom_range(1) ? "p" : "P");
      case ($urandom_range(2))
        0: ;
        1: q.push_back("+");
        default: q.push_back("-");
      endcase
      case ($urandom_range(3))
        0: s = $sformatf("%0d", $urandom_range(40));
        1, 2: s = $sformatf("%0d", $urandom_range(1150, 950));
        default: begin
          s = "";
          repeat ($urandom_range(12, 8)) s = {s, $sformatf("%0d", $urandom_range(9))};
        end
      endcase
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    end
    q.push_back(end_char());
    return q;
  endfunction

  function automatic char_q_t make_broken();
    char_q_t q;
    repeat ($urandom_range(4, 1)) q.push_back(hex_char($urandom_range(15)));
    case ($urandom_range(2))
      0: begin
        q.push_back(".");
        q.push_back(hex_char($urandom_range(15)));
        q.push_back(".");
      end
      1: begin
        q.push_back($urandom_range(1) ? "p" : "P");
        if ($urandom_range(1)) q.push_back($urandom_range(1) ? "+" : "-");
        q.push_back(end_char());
      end
      default: q.push_back(bad_char());
    endcase
    q.push_back(end_char());
    return q;
  endfunction

  // one character transfer; the expected result is logged when it is taken
  task automatic send_char(input logic [7:0] c, input bit start, input bit neg);
    int   gap;
    res_t r;
    gap = idle_len(tx_gaps_on);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.start_req <= start;
    in_if.negative  <= neg;
    do @(posedge clk); while (!in_if.ready);
    if (start || !number_closed) chars_taken++;
    if (parse_char(c, start, neg, r)) parsed_q.push_back(r);
  endtask

  task automatic send_chars(char_q_t txt, bit neg);
    foreach (txt[i]) send_char(txt[i], i == 0, neg);
  endtask

  // sender goes quiet until every pending result has come out
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (parsed_q.size() != 0);
  endtask

  // out of reset a character without start opens a positive number
  task automatic test_reset_default();
    send_char("1", 1'b0, 1'b0);
    send_char(" ", 1'b0, 1'b0);
    send_char("A", 1'b0, 1'b0);
  endtask

  task automatic test_zero_forms();
    send_chars(text_of("", 8'h00), 1'b1);
    send_chars(text_of("0.8", 8'hff), 1'b0);
  endtask

  task automatic test_bad_chars();
    send_chars(text_of("a.", "."), 1'b1);
    send_chars(text_of("3", "g"), 1'b0);
  endtask

  task automatic test_exponent_edges();
    send_chars(text_of("Fp+", "x"), 1'b0);
    send_chars(text_of("1P-2000", "/"), 1'b1);
    send_chars(text_of("fp1100", ","), 1'b0);
  endtask

  task automatic test_output_backpressure();
    char_q_t q;
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 300;
    repeat (30) begin
      q = {hex_char($urandom_range(15, 1)), end_char()};
      send_chars(q, 1'($urandom_range(1)));
    end
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_numbers(int char_goal);
    char_q_t q;
    int      pick;
    while (chars_taken < char_goal) begin
      if ($urandom_range(29) == 0) begin
        tx_gaps_on = ($urandom_range(3) != 0);
        rx_stalls_on = ($urandom_range(3) != 0);
      end
      pick = $urandom_range(99);
      if (pick < 85) q = make_well_formed();
      else if (pick < 93) q = make_broken();
      else begin
        q = {};
        repeat ($urandom_range(12, 1)) q.push_back(8'($urandom_range(255)));
        q.push_back(end_char());
      end
      send_chars(q, 1'($urandom_range(1)));
      // stray characters after the end are dropped by the block
      if ($urandom_range(7) == 0) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // result side: random stalls plus long hold-offs on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        stall_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(99) < 25) begin
        stall_left = idle_len(1'b1);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.double_bits  = out_if.double_bits;
      got.raw_mant     = out_if.raw_mant;
      got.raw_mant_ok  = out_if.raw_mant_ok;
      got.digits_found = out_if.digits_found;
      got.used_count   = out_if.used_count;
      if (parsed_q.size() == 0) begin
        note_failure($sformatf("unexpected result: %h %h %b %b %0d", got.double_bits,
                               got.raw_mant, got.raw_mant_ok, got.digits_found,
                               got.used_count));
      end else begin
        want = parsed_q.pop_front();
        if (got.double_bits !== want.double_bits || got.raw_mant !== want.raw_mant ||
            got.raw_mant_ok !== want.raw_mant_ok || got.digits_found !== want.digits_found ||
            got.used_count !== want.used_count)
          note_failure($sformatf(
            "result mismatch: expected %h %h %b %b %0d, got %h %h %b %b %0d",
            want.double_bits, want.raw_mant, want.raw_mant_ok, want.digits_found,
            want.used_count, got.double_bits, got.raw_mant, got.raw_mant_ok,
            got.digits_found, got.used_count));
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_if.valid     <= 1'b0;
    in_if.char_code <= '0;
    in_if.start_req <= 1'b0;
    in_if.negative  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    test_reset_default();
    test_zero_forms();
    test_bad_chars();
    test_exponent_edges();
    wait_for_results();
    test_output_backpressure();
    wait_for_results();
    test_random_numbers(1050);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/hfp_pkg.sv
design/hfp_in_if.sv
design/hfp_out_if.sv
design/hfp_scan.sv
design/hfp_pack.sv
design/hex_float_text_parser_unit.sv
dv/tb_top.sv
